// ===== hdl/rbd_pkg.sv =====
// Shared types and constants for the RGBA 2x2 box downsampler.
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 2048;
    localparam int DEFAULT_MAX_HEIGHT = 2048;

    localparam int CFG_W   = 12;
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = CHAN_W + 1;
    localparam int TRI_W   = CHAN_W + 2;
    localparam int LANES   = 4;
    localparam int ENTRY_W = LANES * SUM_W;
    localparam int IDX_W   = 1;

    localparam logic [CFG_W-1:0] CFG_RESET = 12'd2048;

    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } flags_t;

endpackage

// ===== hdl/rbd_lane.sv =====
// One colour channel lane: held pixel, pair sum and block average.
`timescale 1ns / 1ps

module rbd_lane
    import rbd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  chan_t cur,
    input  logic  hold_en,
    input  logic  load_en,
    input  sum_t  stored,
    output sum_t  pair,
    output chan_t avg
);

    chan_t             held_reg;
    sum_t              pair_reg;
    logic [TRI_W-1:0]  total;

    assign pair  = SUM_W'(held_reg) + SUM_W'(cur);
    assign total = TRI_W'(stored) + TRI_W'(pair_reg);
    assign avg   = total[TRI_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (hold_en)
        begin
            held_reg <= cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            pair_reg <= pair;
        end
    end

endmodule

// ===== hdl/rbd_out.sv =====
// Output stage that merges the lane averages into one registered result request.
`timescale 1ns / 1ps

module rbd_out
    import rbd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  chan_t  avg [LANES],
    input  flags_t flags,
    input  logic   stall,
    output logic   free,
    output logic   valid,
    output chan_t  red,
    output chan_t  green,
    output chan_t  blue,
    output chan_t  alpha,
    output logic   row_end,
    output logic   frame_end
);

    logic   valid_reg;
    logic   valid_next;
    chan_t  pix_reg [LANES];
    flags_t flags_reg;

    assign free = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg   <= avg;
            flags_reg <= flags;
        end
    end

    assign valid     = valid_reg;
    assign red       = pix_reg[0];
    assign green     = pix_reg[1];
    assign blue      = pix_reg[2];
    assign alpha     = pix_reg[3];
    assign row_end   = flags_reg.row_end;
    assign frame_end = flags_reg.frame_end;

endmodule

// ===== hdl/rgba_box_downsample_2x2_unit.sv =====
// Top level of the RGBA 2x2 box downsampler with its pair-sum line buffer.
// Throughput: one pixel per cycle unless stalled; the line buffer port and four lanes sustain it.
// An odd-row, odd-column pixel loads stage one; the output register then shows its result.
// Reset: counters, held pixel and valid flags clear at once; the line buffer is not cleared.
// Both size registers reset to 2048.
`timescale 1ns / 1ps

module rgba_box_downsample_2x2_unit
    import rbd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  chan_t            in_red,
    input  chan_t            in_green,
    input  chan_t            in_blue,
    input  chan_t            in_alpha,
    output logic             out_valid,
    input  logic             out_stall,
    output chan_t            out_red,
    output chan_t            out_green,
    output chan_t            out_blue,
    output chan_t            out_alpha,
    output logic             row_end,
    output logic             frame_end
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int EWX        = $clog2(MAX_WIDTH + 1);
    localparam int EHX        = $clog2(MAX_HEIGHT + 1);
    localparam int EW         = (EWX > EHX) ? EWX : EHX;
    localparam int DW         = (EW > CFG_W) ? EW : CFG_W;
    localparam int CMPW       = DW + 1;

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_next;
    logic [RW-1:0]      row_reg;
    logic [RW-1:0]      row_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    flags_t             s1_flags_reg;
    logic [ENTRY_W-1:0] rd_reg;
    logic [ENTRY_W-1:0] line_mem [LINE_DEPTH];

    logic [CMPW-1:0]    w_eff;
    logic [CMPW-1:0]    h_eff;
    logic [CMPW-1:0]    width_ext;
    logic [CMPW-1:0]    height_ext;
    logic [CMPW-1:0]    half_col;
    logic [CMPW-1:0]    half_row;
    logic [CMPW-1:0]    addr_full;
    logic [ADDR_W-1:0]  addr;
    logic               last_col;
    logic               last_row;
    logic               accept;
    logic               do_hold;
    logic               do_store;
    logic               do_emit;
    logic               s1_advance;
    logic               out_free;
    flags_t             flags_now;
    logic [ENTRY_W-1:0] entry;
    chan_t              cur_px [LANES];
    chan_t              avg_px [LANES];

    assign cur_px[0] = in_red;
    assign cur_px[1] = in_green;
    assign cur_px[2] = in_blue;
    assign cur_px[3] = in_alpha;

    assign width_ext  = CMPW'(width_reg);
    assign height_ext = CMPW'(height_reg);

    always_comb
    begin
        if (width_ext < CMPW'(2))
        begin
            w_eff = CMPW'(2);
        end
        else if (width_ext > CMPW'(MAX_WIDTH))
        begin
            w_eff = CMPW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_ext;
        end
        if (height_ext < CMPW'(2))
        begin
            h_eff = CMPW'(2);
        end
        else if (height_ext > CMPW'(MAX_HEIGHT))
        begin
            h_eff = CMPW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_ext;
        end
    end

    assign last_col = (CMPW'(col_reg) + CMPW'(1)) >= w_eff;
    assign last_row = (CMPW'(row_reg) + CMPW'(1)) >= h_eff;
    assign half_col = CMPW'(col_reg >> 1);
    assign half_row = CMPW'(row_reg >> 1);

    assign addr_full = (half_col >= CMPW'(LINE_DEPTH)) ? (half_col - CMPW'(LINE_DEPTH))
                                                       : half_col;
    assign addr      = addr_full[ADDR_W-1:0];

    assign flags_now.row_end   = (half_col + CMPW'(1)) >= (w_eff >> 1);
    assign flags_now.frame_end = flags_now.row_end && ((half_row + CMPW'(1)) >= (h_eff >> 1));

    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign accept     = in_valid && !in_stall;

    assign do_hold  = accept && !col_reg[0] && !last_col;
    assign do_store = accept && col_reg[0] && !row_reg[0] && !last_row;
    assign do_emit  = accept && col_reg[0] && row_reg[0];

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : RW'(row_reg + 1'b1);
            end
            else
            begin
                col_next = CW'(col_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (do_emit)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_RESET;
            height_reg   <= CFG_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                    REG_SOURCE_HEIGHT: height_reg <= cfg_data;
                    default:           width_reg  <= width_reg;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            line_mem[addr] <= entry;
        end
        if (do_emit)
        begin
            rd_reg       <= line_mem[addr];
            s1_flags_reg <= flags_now;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        rbd_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .cur     (cur_px[g]),
            .hold_en (do_hold),
            .load_en (do_emit),
            .stored  (rd_reg[g*SUM_W +: SUM_W]),
            .pair    (entry[g*SUM_W +: SUM_W]),
            .avg     (avg_px[g])
        );
    end

    rbd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_advance),
        .avg       (avg_px),
        .flags     (s1_flags_reg),
        .stall     (out_stall),
        .free      (out_free),
        .valid     (out_valid),
        .red       (out_red),
        .green     (out_green),
        .blue      (out_blue),
        .alpha     (out_alpha),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg)
        else $error("Pending result was dropped while the output was stalled.");

    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!frame_end || row_end))
        else $error("Frame end marked on a pixel that does not end a row.");

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_col |=> col_reg == '0)
        else $error("Column counter did not wrap at the end of a row.");

endmodule

// ===== dv/tb_rgba_box_downsample_2x2_unit.sv =====
// Self-checking testbench for the RGBA 2x2 box downsampler with its own pixel predictor.
`timescale 1ns / 1ps

module tb_rgba_box_downsample_2x2_unit;
    import rbd_pkg::*;

    localparam int LINE_DEPTH    = DEFAULT_MAX_WIDTH / 2;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PIXELS = 1000;
    localparam int WIDE_PIXELS   = 64;
    localparam int TALL_PIXELS   = 80;

    typedef logic [LANES-1:0][CHAN_W-1:0] rgba_t;
    typedef logic [LANES-1:0][SUM_W-1:0]  pair_sums_t;

    typedef struct packed {
        chan_t  red;
        chan_t  green;
        chan_t  blue;
        chan_t  alpha;
        flags_t flags;
    } box_avg_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_write = 1'b0;
    logic [IDX_W-1:0] cfg_index = REG_SOURCE_WIDTH;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    chan_t            in_red    = '0;
    chan_t            in_green  = '0;
    chan_t            in_blue   = '0;
    chan_t            in_alpha  = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    chan_t            out_red;
    chan_t            out_green;
    chan_t            out_blue;
    chan_t            out_alpha;
    logic             row_end;
    logic             frame_end;

    // Predictor state.
    logic [CFG_W-1:0] width_reg  = CFG_RESET;
    logic [CFG_W-1:0] height_reg = CFG_RESET;
    int unsigned      col_pos    = 0;
    int unsigned      row_pos    = 0;
    rgba_t            held_px    = '0;
    pair_sums_t       pair_line [LINE_DEPTH];
    box_avg_t         expected_avgs [$];

    int          mismatch_count = 0;
    int          pixels_sent    = 0;
    int          burst_left     = 0;
    bit          steady_send    = 1'b0;
    int          hold_requests  = 0;
    int          holds_served   = 0;
    int          hold_left      = 0;
    int          stall_pct      = 0;
    int          stall_phase    = 0;
    int unsigned cycle_count    = 0;
    box_avg_t    got_avg;
    box_avg_t    want_avg;

    rgba_box_downsample_2x2_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    always #5 clk = ~clk;

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] value,
                                               input int unsigned top);
        if (value < 2)
        begin
            return 2;
        end
        if (value > top)
        begin
            return top;
        end
        return value;
    endfunction

    function automatic rgba_t make_px(input chan_t r, input chan_t g, input chan_t b,
                                      input chan_t a);
        rgba_t px;
        px[0] = r;
        px[1] = g;
        px[2] = b;
        px[3] = a;
        return px;
    endfunction

    function automatic rgba_t random_pixel();
        rgba_t px;
        for (int c = 0; c < LANES; c++)
        begin
            case ($urandom_range(0, 7))
                0:       px[c] = '0;
                1:       px[c] = '1;
                default: px[c] = chan_t'($urandom_range(0, 255));
            endcase
        end
        return px;
    endfunction

    task automatic predict_box(input rgba_t px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      idx;
        bit               last_col;
        bit               last_row;
        bit               rend;
        logic [TRI_W-1:0] lane_total;
        rgba_t            avg_lanes;
        box_avg_t         avg;
        w        = clamp_size(width_reg, DEFAULT_MAX_WIDTH);
        h        = clamp_size(height_reg, DEFAULT_MAX_HEIGHT);
        idx      = (col_pos >> 1) % LINE_DEPTH;
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        if (col_pos % 2 == 0)
        begin
            if (!last_col)
            begin
                held_px = px;
            end
        end
        else if (row_pos % 2 == 0)
        begin
            if (!last_row)
            begin
                for (int c = 0; c < LANES; c++)
                begin
                    pair_line[idx][c] = SUM_W'(held_px[c]) + SUM_W'(px[c]);
                end
            end
        end
        else
        begin
            for (int c = 0; c < LANES; c++)
            begin
                lane_total   = TRI_W'(pair_line[idx][c]) + TRI_W'(held_px[c])
                             + TRI_W'(px[c]);
                avg_lanes[c] = lane_total[TRI_W-1:2];
            end
            rend                = ((col_pos >> 1) + 1 >= (w >> 1));
            avg.red             = avg_lanes[0];
            avg.green           = avg_lanes[1];
            avg.blue            = avg_lanes[2];
            avg.alpha           = avg_lanes[3];
            avg.flags.row_end   = rend;
            avg.flags.frame_end = rend && ((row_pos >> 1) + 1 >= (h >> 1));
            expected_avgs.push_back(avg);
        end
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
    endtask

    task automatic send_pixel(input rgba_t px);
        int gap;
        if (burst_left <= 0 && !steady_send)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_red   <= px[0];
        in_green <= px[1];
        in_blue  <= px[2];
        in_alpha <= px[3];
        do @(posedge clk); while (in_stall);
        predict_box(px);
        pixels_sent++;
    endtask

    task automatic finish_frame();
        do send_pixel(random_pixel()); while (col_pos != 0 || row_pos != 0);
    endtask

    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_avgs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (index == REG_SOURCE_WIDTH)
        begin
            width_reg = value;
        end
        else
        begin
            height_reg = value;
        end
    endtask

    task automatic set_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        drain_block();
        write_size(REG_SOURCE_WIDTH, w);
        write_size(REG_SOURCE_HEIGHT, h);
    endtask

    // The reset sizes are left in force for the first pixels, then both are cut mid-frame.
    task automatic test_reset_sizes();
        repeat (3) send_pixel(random_pixel());
        drain_block();
        write_size(REG_SOURCE_WIDTH, 12'd2);
        repeat (3) send_pixel(random_pixel());
        drain_block();
        write_size(REG_SOURCE_HEIGHT, 12'd2);
        finish_frame();
    endtask

    task automatic test_corner_pixels();
        set_sizes(12'd2, 12'd2);
        repeat (4) send_pixel(make_px(8'd255, 8'd255, 8'd255, 8'd255));
        send_pixel(make_px(8'd1, 8'd3, 8'd0, 8'd255));
        send_pixel(make_px(8'd1, 8'd0, 8'd2, 8'd255));
        send_pixel(make_px(8'd1, 8'd0, 8'd0, 8'd255));
        send_pixel(make_px(8'd0, 8'd0, 8'd0, 8'd254));
        // Odd width and height: the last column and the last row give nothing.
        set_sizes(12'd3, 12'd3);
        finish_frame();
        // Sizes below the legal range behave as two.
        set_sizes(12'd1, 12'd0);
        repeat (4) send_pixel(make_px(8'd0, 8'd0, 8'd0, 8'd0));
    endtask

    // The widest width runs part of an even row, then the row is cut short.
    task automatic test_widest_row();
        set_sizes(12'd4095, 12'd2);
        repeat (WIDE_PIXELS) send_pixel(random_pixel());
        drain_block();
        write_size(REG_SOURCE_WIDTH, CFG_W'(WIDE_PIXELS));
        finish_frame();
    endtask

    // The tallest height runs a few dozen rows, then the frame is cut short.
    task automatic test_tallest_frame();
        set_sizes(12'd2, 12'd4095);
        repeat (TALL_PIXELS) send_pixel(random_pixel());
        drain_block();
        write_size(REG_SOURCE_HEIGHT, 12'd2);
        finish_frame();
    endtask

    task automatic test_output_hold_off();
        set_sizes(12'd2, 12'd2);
        steady_send = 1'b1;
        hold_requests++;
        repeat (160) send_pixel(random_pixel());
        steady_send = 1'b0;
    endtask

    task automatic test_random_frames();
        int          first_pixel;
        int unsigned frame_len;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        first_pixel = pixels_sent;
        while (pixels_sent - first_pixel < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 9))
                0:       w = CFG_W'($urandom_range(0, 1));
                1:       w = CFG_W'($urandom_range(17, 64));
                default: w = CFG_W'($urandom_range(2, 16));
            endcase
            h = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 1))
                                            : CFG_W'($urandom_range(2, 8));
            set_sizes(w, h);
            if ($urandom_range(0, 4) == 0)
            begin
                frame_len = clamp_size(w, DEFAULT_MAX_WIDTH) * clamp_size(h, DEFAULT_MAX_HEIGHT);
                repeat ($urandom_range(1, frame_len - 1)) send_pixel(random_pixel());
                drain_block();
                // A width change is only made on an even row, so that every line entry
                // read on the following odd row has been written.
                if (row_pos % 2 == 0 && $urandom_range(0, 1) == 1)
                begin
                    write_size(REG_SOURCE_WIDTH, CFG_W'($urandom_range(0, 20)));
                end
                else
                begin
                    write_size(REG_SOURCE_HEIGHT, CFG_W'($urandom_range(0, 9)));
                end
            end
            finish_frame();
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (stall_phase <= 0)
            begin
                stall_phase = $urandom_range(8, 64);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stall_phase--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_avg = {out_red, out_green, out_blue, out_alpha, row_end, frame_end};
            if (expected_avgs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected result request: r=%0d g=%0d b=%0d a=%0d re=%0b fe=%0b",
                             got_avg.red, got_avg.green, got_avg.blue, got_avg.alpha,
                             got_avg.flags.row_end, got_avg.flags.frame_end);
                end
            end
            else
            begin
                want_avg = expected_avgs.pop_front();
                if (got_avg !== want_avg)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected r=%0d g=%0d b=%0d a=%0d re=%0b fe=%0b",
                                 want_avg.red, want_avg.green, want_avg.blue, want_avg.alpha,
                                 want_avg.flags.row_end, want_avg.flags.frame_end);
                        $display("          actual   r=%0d g=%0d b=%0d a=%0d re=%0b fe=%0b",
                                 got_avg.red, got_avg.green, got_avg.blue, got_avg.alpha,
                                 got_avg.flags.row_end, got_avg.flags.frame_end);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** rgba_box_downsample_2x2_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_sizes();
        test_corner_pixels();
        test_widest_row();
        test_tallest_frame();
        test_output_hold_off();
        test_random_frames();
        drain_block();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_avgs.size() == 0)
        begin
            $display("** rgba_box_downsample_2x2_unit: PASSED **");
        end
        else
        begin
            $display("** rgba_box_downsample_2x2_unit: FAILED **");
        end
        $finish;
    end

endmodule
